// ===== rtl/periodic_task_slot_scheduler_defines.svh =====
// Assertion helpers shared by the scheduler RTL.
`ifndef PERIODIC_TASK_SLOT_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_SLOT_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PTSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PTSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ptss_pkg.sv =====
package ptss_pkg;

    typedef enum logic [2:0] {
        OP_ADD        = 3'd0,
        OP_REMOVE     = 3'd1,
        OP_REMOVE_ALL = 3'd2,
        OP_PAUSE      = 3'd3,
        OP_RESUME     = 3'd4,
        OP_SET_PERIOD = 3'd5,
        OP_TICK       = 3'd6,
        OP_PROCESS    = 3'd7
    } t_op;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam int PERIOD_BITS = 16;
    localparam logic [PERIOD_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  task_id;
        logic [15:0] period;
    } t_in_item;

    typedef struct packed {
        logic        fire_valid;
        logic [7:0]  fired_task;
        logic [3:0]  slot_index;
        logic [1:0]  status;
        logic        last;
    } t_out_item;

    // Per-slot verdict from the update logic.
    typedef struct packed {
        logic match;
        logic due;
        logic wr;
    } t_slot_res;

endpackage

// ===== rtl/ptss_ram.sv =====
module ptss_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ptss_slot_alu.sv =====
module ptss_slot_alu #(
    parameter int ID_BITS = 8
) (
    input  ptss_pkg::t_op       i_op,
    input  logic [ID_BITS-1:0]  i_id,
    input  logic [15:0]         i_period,
    input  logic [ID_BITS+32:0] i_entry,
    output logic [ID_BITS+32:0] o_entry,
    output ptss_pkg::t_slot_res o_res
);
    import ptss_pkg::*;

    // entry layout: {task, period, count, running}
    logic [ID_BITS-1:0]     e_task;
    logic [PERIOD_BITS-1:0] e_period;
    logic [PERIOD_BITS-1:0] e_count;
    logic                   e_run;
    logic [PERIOD_BITS-1:0] n_period;
    logic [PERIOD_BITS-1:0] n_count;
    logic                   n_run;

    assign {e_task, e_period, e_count, e_run} = i_entry;

    always_comb begin
        n_period    = e_period;
        n_count     = e_count;
        n_run       = e_run;
        o_res.match = (e_task == i_id);
        o_res.due   = (e_count >= e_period);
        o_res.wr    = 1'b0;
        unique case (i_op)
            OP_PAUSE: begin
                n_run    = 1'b0;
                o_res.wr = o_res.match;
            end
            OP_RESUME: begin
                n_run    = 1'b1;
                o_res.wr = o_res.match;
            end
            OP_SET_PERIOD: begin
                n_period = i_period;
                o_res.wr = o_res.match;
            end
            OP_TICK: begin
                n_count  = e_count + 1'b1;
                o_res.wr = e_run && (e_count != COUNT_MAX);
            end
            OP_PROCESS: begin
                n_count  = '0;
                o_res.wr = o_res.due;
            end
            default: begin
                o_res.wr = 1'b0;
            end
        endcase
    end

    assign o_entry = {e_task, n_period, n_count, n_run};

endmodule

// ===== rtl/periodic_task_slot_scheduler.sv =====
// Channel | Dir | Handshake                 | Beat
// --------+-----+---------------------------+------------------------------------------------
// in      | in  | i_in_valid / o_in_stall   | opcode, task_id, period
// out     | out | o_out_valid / i_out_stall | fire_valid, fired_task, slot_index, status, last
//
// Add and remove all finish when accepted; the other ops scan any used slots one slot per cycle
// unless process holds the scan, through the single slot RAM read port, plus a closing beat.
// No input beat is taken during a scan or while a stalled beat fills the output.
// Process holds the scan at a second due slot until the pending beat is taken.
// Reset clears the slot count and control only; RAM contents above the count
// never affect a result.
`include "periodic_task_slot_scheduler_defines.svh"

module periodic_task_slot_scheduler #(
    parameter int SLOTS   = 16,
    parameter int ID_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ptss_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ptss_pkg::t_out_item o_out_data
);
    import ptss_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;   // slot index bits
    localparam int UW = $clog2(SLOTS + 1);                 // slot count bits
    localparam int EW = ID_BITS + 2 * PERIOD_BITS + 1;     // RAM entry bits
    localparam logic [UW-1:0] USED_FULL = UW'(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [UW-1:0]        r_used, n_used;
    logic [IW-1:0]        r_idx, n_idx;
    t_op                  r_op, n_op;
    logic [ID_BITS-1:0]   r_id, n_id;
    logic [15:0]          r_per, n_per;
    logic                 r_hit, n_hit;
    // process keeps the latest due slot back until it knows whether it is the last
    logic                 r_hv, n_hv;
    logic [ID_BITS-1:0]   r_h_task, n_h_task;
    logic [IW-1:0]        r_h_idx, n_h_idx;
    logic                 r_ov, n_ov;
    t_out_item            r_out, n_out;

    logic                 out_free;
    logic                 in_acc;
    logic                 push;
    t_out_item            push_beat;
    logic [ID_BITS-1:0]   in_id;
    t_op                  in_op;

    logic                 ram_we, ram_re;
    logic [IW-1:0]        ram_waddr, ram_raddr;
    logic [EW-1:0]        ram_wdata, ram_rdata;
    logic [EW-1:0]        alu_entry;
    t_slot_res            alu_res;
    logic [ID_BITS-1:0]   cur_task;
    logic                 last_slot;

    assign out_free   = !r_ov || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_id      = ID_BITS'(i_in_data.task_id);
    assign in_op      = t_op'(i_in_data.opcode);
    assign cur_task   = ram_rdata[EW-1 -: ID_BITS];
    assign last_slot  = (UW'(r_idx) + 1'b1) == r_used;

    ptss_ram #(
        .WIDTH(EW),
        .DEPTH(SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    ptss_slot_alu #(
        .ID_BITS(ID_BITS)
    ) u_alu (
        .i_op    (r_op),
        .i_id    (r_id),
        .i_period(r_per),
        .i_entry (ram_rdata),
        .o_entry (alu_entry),
        .o_res   (alu_res)
    );

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_idx     = r_idx;
        n_op      = r_op;
        n_id      = r_id;
        n_per     = r_per;
        n_hit     = r_hit;
        n_hv      = r_hv;
        n_h_task  = r_h_task;
        n_h_idx   = r_h_idx;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = alu_entry;
        ram_re    = 1'b0;
        ram_raddr = r_idx + 1'b1;
        push      = 1'b0;
        push_beat = '0;
        push_beat.last = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op  = in_op;
                    n_id  = in_id;
                    n_per = i_in_data.period;
                    n_hit = 1'b0;
                    n_hv  = 1'b0;
                    n_idx = '0;
                    unique case (in_op)
                        OP_ADD: begin
                            push = 1'b1;
                            if (r_used == USED_FULL) begin
                                push_beat.status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_used[IW-1:0];
                                ram_wdata = {in_id, i_in_data.period, {PERIOD_BITS{1'b0}}, 1'b1};
                                n_used    = r_used + 1'b1;
                                push_beat.slot_index = 4'(r_used);
                            end
                        end
                        OP_REMOVE_ALL: begin
                            push   = 1'b1;
                            n_used = '0;
                        end
                        default: begin
                            if (r_used == '0) begin
                                n_state = S_DONE;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                n_state   = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // a second due slot pushes the held one out, so it needs room
                if (!(r_op == OP_PROCESS && alu_res.due && r_hv) || out_free) begin
                    ram_re = 1'b1;
                    if (r_op == OP_REMOVE) begin
                        // compaction: every slot past the match moves down by one
                        if (r_hit) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_idx - 1'b1;
                            ram_wdata = ram_rdata;
                        end else if (alu_res.match) begin
                            n_hit = 1'b1;
                        end
                    end else begin
                        ram_we = alu_res.wr;
                        n_hit  = r_hit || alu_res.match;
                    end
                    if (r_op == OP_PROCESS && alu_res.due) begin
                        if (r_hv) begin
                            push                 = 1'b1;
                            push_beat.fire_valid = 1'b1;
                            push_beat.fired_task = 8'(r_h_task);
                            push_beat.slot_index = 4'(r_h_idx);
                            push_beat.last       = 1'b0;
                        end
                        n_hv     = 1'b1;
                        n_h_task = cur_task;
                        n_h_idx  = r_idx;
                    end
                    if (last_slot) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    push    = 1'b1;
                    n_state = S_IDLE;
                    unique case (r_op)
                        OP_PROCESS: begin
                            if (r_hv) begin
                                push_beat.fire_valid = 1'b1;
                                push_beat.fired_task = 8'(r_h_task);
                                push_beat.slot_index = 4'(r_h_idx);
                            end
                        end
                        OP_TICK: begin
                            push_beat.status = ST_OK;
                        end
                        default: begin
                            push_beat.status = r_hit ? ST_OK : ST_NOT_FOUND;
                            if (r_op == OP_REMOVE && r_hit) begin
                                n_used = r_used - 1'b1;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register: a new beat is loaded only when the old one leaves
    always_comb begin
        n_ov  = r_ov && i_out_stall;
        n_out = r_out;
        if (push) begin
            n_ov  = 1'b1;
            n_out = push_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_hv    <= 1'b0;
            r_hit   <= 1'b0;
            r_ov    <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_hv    <= n_hv;
            r_hit   <= n_hit;
            r_ov    <= n_ov;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_id     <= n_id;
        r_per    <= n_per;
        r_h_task <= n_h_task;
        r_h_idx  <= n_h_idx;
        r_out    <= n_out;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    `PTSS_ASSERT_SAME(a_scan_in_range, i_clk, i_rst_n, r_state == S_SCAN, UW'(r_idx) < r_used, "scan index beyond used slots")
    `PTSS_ASSERT_SAME(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= USED_FULL, "slot count above table size")
    `PTSS_ASSERT_SAME(a_hold_only_process, i_clk, i_rst_n, r_hv && r_state != S_IDLE, r_op == OP_PROCESS, "held fire outside process")
    `PTSS_ASSERT_NEXT(a_add_counts, i_clk, i_rst_n, in_acc && in_op == OP_ADD && r_used != USED_FULL, r_used == $past(r_used) + 1'b1, "add did not grow table")

endmodule
